>>> hw/rtl/bitonic_sorter_defines.svh
// assertion macros for the bitonic sorter
// used by the top level only; the clock is clk and the reset is rst
`ifndef BITONIC_SORTER_DEFINES_SVH
`define BITONIC_SORTER_DEFINES_SVH

`ifndef ASSERT_OFF
// antecedent holds in a cycle, consequent holds in the same cycle
`define BS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bitonic_sorter: assertion failed");
// antecedent holds in a cycle, consequent holds in the next cycle
`define BS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bitonic_sorter: assertion failed");
`else
`define BS_ASSERT_SAME(lbl, ante, cons)
`define BS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/bs_pkg.sv
// shared types and constants of the bitonic sorter
// no dependencies; used by bs_cell and bitonic_sorter
package bs_pkg;

  // block length, a power of two from 2 to 64
  localparam int COUNT  = 64;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(COUNT + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam cnt_t CNT_LAST = cnt_t'(COUNT - 1);

  // per-cell control for one cycle
  typedef struct packed {
    logic shift;       // take the right neighbor's value
    logic with_right;  // low member of a compare-exchange pair
    logic with_left;   // high member of a compare-exchange pair
    logic ascending;   // sort direction of this block
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SORT = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

>>> hw/rtl/bs_cell.sv
// one cell of the sorting chain: holds one element
// depends on bs_pkg for the data and control types
module bs_cell (
  input  logic              clk,
  input  bs_pkg::cell_ctrl_t ctrl,
  input  bs_pkg::data_t     left_val,
  input  bs_pkg::data_t     right_val,
  output bs_pkg::data_t     val
);

  logic          swap_right;
  logic          swap_left;
  bs_pkg::data_t val_next;

  // out-of-order tests against each neighbor; equal values stay put
  assign swap_right = ctrl.ascending ? (val > right_val) : (val < right_val);
  assign swap_left  = ctrl.ascending ? (left_val > val) : (left_val < val);

  // shift, compare-exchange or hold
  always_comb begin
    val_next = val;
    if (ctrl.shift) begin
      val_next = right_val;
    end else if (ctrl.with_right) begin
      if (swap_right) begin
        val_next = right_val;
      end
    end else if (ctrl.with_left) begin
      if (swap_left) begin
        val_next = left_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

>>> hw/rtl/bitonic_sorter.sv
// block sorter: a chain of COUNT cells loaded by shifting, sorted by
// COUNT rounds of odd-even compare-exchange, then shifted out from cell 0.
// after the last input beat the block is sorted, then emitted one beat per cycle while out_stall is low;
// no new block is taken until the last beat of the previous block has been emitted.
// reset clears the fill count and state and sets ascending to 1; cell data is not reset.
// depends on bs_pkg, bs_cell and bitonic_sorter_defines.svh
`include "bitonic_sorter_defines.svh"

module bitonic_sorter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [bs_pkg::DATA_W-1:0] value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [bs_pkg::DATA_W-1:0] sorted_value,
  output logic                            last
);

  bs_pkg::state_t state;
  bs_pkg::state_t state_next;
  bs_pkg::cnt_t   count;
  bs_pkg::cnt_t   count_next;
  logic           ascending;
  logic           dir;
  logic           in_accept;
  logic           out_accept;
  logic           shift;
  logic           sorting;
  logic           phase;

  bs_pkg::data_t      cell_val  [bs_pkg::COUNT];
  bs_pkg::cell_ctrl_t cell_ctrl [bs_pkg::COUNT];

  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;

  // handshake and output
  assign in_stall     = (state != bs_pkg::ST_LOAD);
  assign out_valid    = (state == bs_pkg::ST_EMIT);
  assign sorted_value = cell_val[0];
  assign last         = (state == bs_pkg::ST_EMIT) && (count == bs_pkg::CNT_LAST);

  assign shift   = in_accept || out_accept;
  assign sorting = (state == bs_pkg::ST_SORT);
  assign phase   = count[0];

  // direction register
  always_ff @(posedge clk) begin
    if (rst) begin
      ascending <= 1'b1;
    end else if (cfg_we) begin
      ascending <= cfg_wdata;
    end
  end

  // direction is sampled by the beat that completes the block
  always_ff @(posedge clk) begin
    if (rst) begin
      dir <= 1'b1;
    end else if (in_accept && (count == bs_pkg::CNT_LAST)) begin
      dir <= ascending;
    end
  end

  // sequencer: load, sort rounds, emit
  always_comb begin
    state_next = state;
    count_next = count;
    case (state)
      bs_pkg::ST_LOAD: begin
        if (in_accept) begin
          if (count == bs_pkg::CNT_LAST) begin
            state_next = bs_pkg::ST_SORT;
            count_next = '0;
          end else begin
            count_next = count + 1'b1;
          end
        end
      end
      bs_pkg::ST_SORT: begin
        if (count == bs_pkg::CNT_LAST) begin
          state_next = bs_pkg::ST_EMIT;
          count_next = '0;
        end else begin
          count_next = count + 1'b1;
        end
      end
      bs_pkg::ST_EMIT: begin
        if (out_accept) begin
          if (count == bs_pkg::CNT_LAST) begin
            state_next = bs_pkg::ST_LOAD;
            count_next = '0;
          end else begin
            count_next = count + 1'b1;
          end
        end
      end
      default: begin
        state_next = bs_pkg::ST_LOAD;
        count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bs_pkg::ST_LOAD;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // chain of cells
  for (genvar i = 0; i < bs_pkg::COUNT; i++) begin : g_cell
    localparam bit HAS_RIGHT = (i < bs_pkg::COUNT - 1);
    localparam bit HAS_LEFT  = (i > 0);
    localparam bit RPAR      = (i % 2) != 0;
    localparam bit LPAR      = (i > 0) ? (((i - 1) % 2) != 0) : 1'b0;

    bs_pkg::data_t left_in;
    bs_pkg::data_t right_in;

    if (HAS_LEFT) begin : g_left
      assign left_in = cell_val[i-1];
    end else begin : g_edge_left
      assign left_in = '0;
    end

    if (HAS_RIGHT) begin : g_right
      assign right_in = cell_val[i+1];
    end else begin : g_edge_right
      assign right_in = value;
    end

    // pairs start at even cells in even rounds, odd cells in odd rounds
    assign cell_ctrl[i].shift      = shift;
    assign cell_ctrl[i].with_right = sorting && HAS_RIGHT && (phase == RPAR);
    assign cell_ctrl[i].with_left  = sorting && HAS_LEFT && (phase == LPAR);
    assign cell_ctrl[i].ascending  = dir;

    bs_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[i]),
      .left_val  (left_in),
      .right_val (right_in),
      .val       (cell_val[i])
    );
  end

  // checks
  `BS_ASSERT_SAME(a_no_load_while_emit, out_valid, in_stall)
  `BS_ASSERT_NEXT(a_full_block_sorts, in_accept && (count == bs_pkg::CNT_LAST), sorting && in_stall && !out_valid)
  `BS_ASSERT_NEXT(a_last_reopens_load, out_accept && last, !out_valid && !in_stall && (count == '0))

endmodule

>>> dv/bitonic_sorter_test.sv
// self-checking testbench for bitonic_sorter: fills blocks of COUNT elements,
// predicts each sorted block with its own bitonic network, checks every output beat
// depends on bs_pkg and the bitonic_sorter rtl
module bitonic_sorter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int NUM_CORNERS  = 9;
  localparam int RANDOM_BLOCKS = 2;

  typedef struct {
    bs_pkg::data_t sorted_value;
    logic          last;
  } sorted_beat_t;

  // dut connections
  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic          cfg_wdata = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  bs_pkg::data_t value = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  bs_pkg::data_t sorted_value;
  logic          last;

  // testbench state
  bs_pkg::data_t stim_values[$];
  bs_pkg::data_t block_fill[$];
  sorted_beat_t  sorted_queue[$];
  bs_pkg::data_t sort_buf[bs_pkg::COUNT];
  logic          dir_model = 1'b1;
  logic          in_took = 1'b0;
  logic          out_took = 1'b0;
  bit            idle_on = 1'b1;
  int            in_gap = 0;
  int            out_wait = 0;
  int            fail_count = 0;
  int            cycle_count = 0;

  bitonic_sorter u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_value (sorted_value),
    .last         (last)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // corner values of a signed 32-bit element
  function automatic bs_pkg::data_t corner_value(input int idx);
    case (idx)
      0: return bs_pkg::data_t'(32'h8000_0000);
      1: return bs_pkg::data_t'(32'h7fff_ffff);
      2: return bs_pkg::data_t'(32'h0000_0000);
      3: return bs_pkg::data_t'(32'hffff_ffff);
      4: return bs_pkg::data_t'(32'h0000_0001);
      5: return bs_pkg::data_t'(32'h8000_0001);
      6: return bs_pkg::data_t'(32'h7fff_fffe);
      7: return bs_pkg::data_t'(32'h5555_5555);
      default: return bs_pkg::data_t'(32'haaaa_aaaa);
    endcase
  endfunction

  // mostly full-range values, some narrow ones for duplicates, some corners
  function automatic bs_pkg::data_t rand_element();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return bs_pkg::data_t'($urandom);
    else if (pick < 8) return bs_pkg::data_t'(int'($urandom_range(0, 8)) - 4);
    else return corner_value($urandom_range(0, NUM_CORNERS - 1));
  endfunction

  // bitonic network over sort_buf: sub-blocks alternate up/down, final merge follows up_dir
  function automatic void bitonic_network(input logic up_dir);
    int            k;
    int            j;
    int            i;
    int            p;
    logic          dir;
    logic          gt;
    bs_pkg::data_t t;
    for (k = 2; k <= bs_pkg::COUNT; k = k * 2) begin
      for (j = k / 2; j > 0; j = j / 2) begin
        for (i = 0; i < bs_pkg::COUNT; i++) begin
          p = i ^ j;
          if (p > i) begin
            dir = (k == bs_pkg::COUNT) ? up_dir : ((i & k) == 0);
            gt  = (sort_buf[i] > sort_buf[p]);
            if (gt == dir) begin
              t           = sort_buf[i];
              sort_buf[i] = sort_buf[p];
              sort_buf[p] = t;
            end
          end
        end
      end
    end
  endfunction

  // input driver: one draw of idle cycles per beat, payload held while stalled
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_took) begin
        // beat still waiting for acceptance
      end else if (in_gap > 0) begin
        in_gap   <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (stim_values.size() > 0) begin
        in_valid <= 1'b1;
        value    <= stim_values.pop_front();
        in_gap   <= idle_on ? int'($urandom_range(0, 4)) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall: one draw of stall cycles per result beat
  always @(negedge clk) begin
    if (!rst) begin
      if (out_took) out_wait = idle_on ? int'($urandom_range(0, 4)) : 0;
      if (out_valid && out_wait > 0) begin
        out_stall <= 1'b1;
        out_wait  = out_wait - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor: predict on block completion, compare each output beat
  always @(posedge clk) begin : monitor
    sorted_beat_t want;
    int n;
    cycle_count <= cycle_count + 1;
    if (rst) begin
      dir_model <= 1'b1;
      in_took   <= 1'b0;
      out_took  <= 1'b0;
      block_fill.delete();
    end else begin
      if (cfg_we) dir_model <= cfg_wdata;
      in_took  <= in_valid && !in_stall;
      out_took <= out_valid && !out_stall;
      // input beat
      if (in_valid && !in_stall) begin
        block_fill = {block_fill, value};
        if (block_fill.size() == bs_pkg::COUNT) begin
          for (n = 0; n < bs_pkg::COUNT; n++) sort_buf[n] = block_fill[n];
          bitonic_network(dir_model);
          for (n = 0; n < bs_pkg::COUNT; n++) begin
            want.sorted_value = sort_buf[n];
            want.last         = (n == bs_pkg::COUNT - 1);
            sorted_queue = {sorted_queue, want};
          end
          block_fill.delete();
        end
      end
      // output beat
      if (out_valid && !out_stall) begin
        if (sorted_queue.size() == 0) begin
          $error("unexpected beat: sorted_value %0d last %0b", sorted_value, last);
          fail_count++;
        end else begin
          want = sorted_queue.pop_front();
          if (sorted_value !== want.sorted_value) begin
            $error("sorted_value: expected %0d, actual %0d", want.sorted_value, sorted_value);
            fail_count++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, last);
            fail_count++;
          end
        end
      end
    end
    // timeout
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // wait until every queued element is sent and every sorted beat has come back
  task automatic wait_drained();
    while (stim_values.size() != 0 || in_valid || block_fill.size() != 0 ||
           sorted_queue.size() != 0)
      @(posedge clk);
  endtask

  // one block: optional direction write while idle, then COUNT elements
  task automatic run_block(input logic dir, input bit write_dir, input bit idle,
                           input bit directed);
    int n;
    wait_drained();
    repeat (bs_pkg::COUNT + 8) @(posedge clk);
    if (write_dir) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_wdata <= dir;
      @(negedge clk);
      cfg_we    <= 1'b0;
    end
    idle_on = idle;
    for (n = 0; n < bs_pkg::COUNT; n++) begin
      if (directed) begin
        stim_values = {stim_values, corner_value((n * (dir ? 1 : 5)) % NUM_CORNERS)};
      end else begin
        stim_values = {stim_values, rand_element()};
      end
    end
  endtask

  // stimulus sequence
  initial begin : stimulus
    int b;
    logic dir;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // corner values with the reset direction, then descending
    run_block(1'b1, 1'b0, 1'b1, 1'b1);
    run_block(1'b0, 1'b1, 1'b1, 1'b1);

    // random blocks, both directions, the last one without idling
    for (b = 0; b < RANDOM_BLOCKS; b++) begin
      dir = (b == 0) ? 1'b1 : (b == 1) ? 1'b0 : logic'($urandom_range(0, 1));
      run_block(dir, 1'b1, (b != RANDOM_BLOCKS - 1), 1'b0);
    end

    wait_drained();
    repeat (3 * bs_pkg::COUNT + 16) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> bitonic_sorter.f
+incdir+hw/rtl
hw/rtl/bs_pkg.sv
hw/rtl/bs_cell.sv
hw/rtl/bitonic_sorter.sv
dv/bitonic_sorter_test.sv
